### hw/rtl/ppfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority payload FIFO package
// Shared constants, command and result codes, and the word types of both
// channels.
// ----------------------------------------------------------------------------
package ppfs_pkg;

  localparam int DEF_QUEUE_DEPTH   = 8;
  localparam int DEF_PAYLOAD_BYTES = 64;
  localparam int MAX_RUN           = 64;
  localparam int RUN_W             = $clog2(MAX_RUN + 1);

  typedef enum logic [1:0] {
    CMD_UNREL_WR = 2'd0,
    CMD_REL_WR   = 2'd1,
    CMD_READ     = 2'd2,
    CMD_RESET    = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    KIND_ACK        = 2'd0,
    KIND_REL_DATA   = 2'd1,
    KIND_UNREL_DATA = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_PENDING  = 2'd3
  } status_e;

  typedef struct packed {
    command_e   command;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    status_e    status;
    logic [7:0] out_byte;
    logic [5:0] byte_index;
    logic       end_of_run;
  } out_word_t;

endpackage

### hw/rtl/ppfs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command word per handshake.
// ----------------------------------------------------------------------------
interface ppfs_in_if;
  import ppfs_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ppfs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result word per handshake.
// ----------------------------------------------------------------------------
interface ppfs_out_if;
  import ppfs_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ppfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/priority_payload_fifo_with_snapshot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority payload FIFO with latest-value slot
// Reliable payloads queue in a ring; unreliable payloads replace one slot.
// ----------------------------------------------------------------------------
// Usage: commands enter on in_i, one word per handshake. Write bytes stream
// in one per cycle while no result waits, and go straight into the byte
// memory while there is room, into the ring slot at the tail or into the
// spare bank of the latest-value slot. The last byte of a write gives one
// acknowledge word with its status. A reset command gives one acknowledge,
// and a read with nothing stored one word of kind nothing available. An
// acknowledge is in the output register right after the accepting edge. A
// reliable read passes the length memory, ST_RLEN, the byte memory and the
// output register; an unreliable read skips the length. Then one data word
// leaves per cycle while out_o does not stall. Non-final write bytes give no
// result. The next command is taken once the final word of the current one
// is registered and out_o does not stall. Results wait in an output register
// while out_o stalls; the block then holds the read stream and takes no new
// command. After rst_ni both stores are empty at once.
// ----------------------------------------------------------------------------
module priority_payload_fifo_with_snapshot #(
  parameter int QUEUE_DEPTH   = ppfs_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BYTES = ppfs_pkg::DEF_PAYLOAD_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppfs_in_if.sink    in_i,
  ppfs_out_if.source out_o
);
  import ppfs_pkg::*;

  localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = CNTW + 1;
  localparam int SW   = $clog2(QUEUE_DEPTH + 2);
  localparam int IW   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int LW   = $clog2(PAYLOAD_BYTES + 1);
  localparam int AW   = SW + IW;
  localparam int XW   = LW + RUN_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RLEN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    WK_NONE  = 2'd0,
    WK_UNREL = 2'd1,
    WK_REL   = 2'd2
  } wkind_e;

  state_e           state_q, state_d;
  logic [QW-1:0]    head_q, head_d;
  logic [CNTW-1:0]  rcount_q, rcount_d;
  logic [LW-1:0]    latest_len_q, latest_len_d;
  logic             lat_sel_q, lat_sel_d;
  logic [LW-1:0]    stg_cnt_q, stg_cnt_d;
  wkind_e           wkind_q, wkind_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;
  logic             dv_q, dv_d;
  logic [RUN_W-1:0] fc_q, fc_d;
  logic [RUN_W-1:0] ei_q, ei_d;
  logic [RUN_W-1:0] lim_q, lim_d;
  logic [SW-1:0]    slot_q, slot_d;
  kind_e            cls_q, cls_d;

  logic             in_acc;
  logic             out_free;
  command_e         cmd;
  logic             is_rel;
  wkind_e           wr_kind;
  logic             same_kind;
  logic [LW-1:0]    cnt_eff;
  logic             ovf_eff;
  logic             room;
  logic [LW-1:0]    n_len;
  logic             ring_full;
  logic [SUMW-1:0]  tail_sum;
  logic [QW-1:0]    tail;
  logic [SW-1:0]    unrel_slot;
  logic             out_load;
  logic             more;
  logic             last_b;

  logic             bram_we, bram_re;
  logic [AW-1:0]    bram_waddr, bram_raddr;
  logic [7:0]       bram_rdata;
  logic             lram_we, lram_re;
  logic [LW-1:0]    lram_rdata;

  function automatic logic [RUN_W-1:0] clamp_run(input logic [LW-1:0] len);
    logic [XW-1:0] wide;
    wide = XW'(len);
    if (wide > XW'(MAX_RUN)) begin
      clamp_run = RUN_W'(MAX_RUN);
    end else begin
      clamp_run = RUN_W'(len);
    end
  endfunction

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cmd         = in_i.data.command;

  assign is_rel      = (cmd == CMD_REL_WR);
  assign wr_kind     = is_rel ? WK_REL : WK_UNREL;
  assign same_kind   = (wkind_q == wr_kind);
  assign cnt_eff     = same_kind ? stg_cnt_q : '0;
  assign ovf_eff     = same_kind && ovf_q;
  assign room        = cnt_eff < LW'(PAYLOAD_BYTES);
  assign n_len       = cnt_eff + LW'(1);
  assign ring_full   = rcount_q >= CNTW'(QUEUE_DEPTH);
  assign tail_sum    = SUMW'(head_q) + SUMW'(rcount_q);
  assign tail        = (tail_sum >= SUMW'(QUEUE_DEPTH)) ?
                       QW'(tail_sum - SUMW'(QUEUE_DEPTH)) : QW'(tail_sum);
  assign unrel_slot  = SW'(QUEUE_DEPTH) + SW'(!lat_sel_q);

  assign out_load    = (state_q == ST_EMIT) && dv_q && out_free;
  assign more        = fc_q < lim_q;
  assign last_b      = (ei_q == lim_q - RUN_W'(1));

  assign bram_we     = in_acc && (cmd inside {CMD_UNREL_WR, CMD_REL_WR}) && room &&
                       (!is_rel || !ring_full);
  assign bram_waddr  = {(is_rel ? SW'(tail) : unrel_slot), IW'(cnt_eff)};
  assign bram_re     = (state_q == ST_EMIT) && more && (!dv_q || out_load);
  assign bram_raddr  = {slot_q, IW'(fc_q)};

  assign lram_re     = in_acc && (cmd == CMD_READ) && (rcount_q != '0);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    rcount_d     = rcount_q;
    latest_len_d = latest_len_q;
    lat_sel_d    = lat_sel_q;
    stg_cnt_d    = stg_cnt_q;
    wkind_d      = wkind_q;
    ovf_d        = ovf_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;
    dv_d         = dv_q;
    fc_d         = fc_q;
    ei_d         = ei_q;
    lim_d        = lim_q;
    slot_d       = slot_q;
    cls_d        = cls_q;
    lram_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_d.kind       = KIND_ACK;
          out_d.status     = STAT_OK;
          out_d.out_byte   = '0;
          out_d.byte_index = '0;
          out_d.end_of_run = 1'b1;
          if (cmd inside {CMD_UNREL_WR, CMD_REL_WR}) begin
            if (!in_i.data.last_byte) begin
              wkind_d   = wr_kind;
              stg_cnt_d = room ? n_len : cnt_eff;
              ovf_d     = ovf_eff || !room;
            end else begin
              wkind_d     = WK_NONE;
              stg_cnt_d   = '0;
              ovf_d       = 1'b0;
              out_valid_d = 1'b1;
              if (ovf_eff || !room) begin
                out_d.status = STAT_TOO_LONG;
              end else if (is_rel) begin
                if (ring_full) begin
                  out_d.status = STAT_FULL;
                end else begin
                  lram_we  = 1'b1;
                  rcount_d = rcount_q + CNTW'(1);
                end
              end else if (rcount_q != '0) begin
                out_d.status = STAT_PENDING;
              end else begin
                lat_sel_d    = !lat_sel_q;
                latest_len_d = n_len;
              end
            end
          end else begin
            wkind_d   = WK_NONE;
            stg_cnt_d = '0;
            ovf_d     = 1'b0;
            if (cmd == CMD_RESET) begin
              head_d       = '0;
              rcount_d     = '0;
              latest_len_d = '0;
              out_valid_d  = 1'b1;
            end else if (rcount_q != '0) begin
              cls_d    = KIND_REL_DATA;
              slot_d   = SW'(head_q);
              head_d   = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
              rcount_d = rcount_q - CNTW'(1);
              state_d  = ST_RLEN;
            end else if (latest_len_q != '0) begin
              cls_d   = KIND_UNREL_DATA;
              slot_d  = SW'(QUEUE_DEPTH) + SW'(lat_sel_q);
              lim_d   = clamp_run(latest_len_q);
              fc_d    = '0;
              dv_d    = 1'b0;
              state_d = ST_EMIT;
            end else begin
              out_d.kind  = KIND_NONE;
              out_valid_d = 1'b1;
            end
          end
        end
      end
      ST_RLEN: begin
        lim_d   = clamp_run(lram_rdata);
        fc_d    = '0;
        dv_d    = 1'b0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (bram_re) begin
          fc_d = fc_q + RUN_W'(1);
          ei_d = fc_q;
          dv_d = 1'b1;
        end else if (out_load) begin
          dv_d = 1'b0;
        end
        if (out_load) begin
          out_valid_d      = 1'b1;
          out_d.kind       = cls_q;
          out_d.status     = STAT_OK;
          out_d.out_byte   = bram_rdata;
          out_d.byte_index = ei_q[5:0];
          out_d.end_of_run = last_b;
          if (last_b) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      rcount_q     <= '0;
      latest_len_q <= '0;
      lat_sel_q    <= 1'b0;
      stg_cnt_q    <= '0;
      wkind_q      <= WK_NONE;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      dv_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      rcount_q     <= rcount_d;
      latest_len_q <= latest_len_d;
      lat_sel_q    <= lat_sel_d;
      stg_cnt_q    <= stg_cnt_d;
      wkind_q      <= wkind_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
      dv_q         <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    fc_q   <= fc_d;
    ei_q   <= ei_d;
    lim_q  <= lim_d;
    slot_q <= slot_d;
    cls_q  <= cls_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  ppfs_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW),
    .AW   (AW)
  ) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (bram_we),
    .waddr_i(bram_waddr),
    .wdata_i(in_i.data.data_byte),
    .re_i   (bram_re),
    .raddr_i(bram_raddr),
    .rdata_o(bram_rdata)
  );

  ppfs_ram #(
    .WIDTH(LW),
    .DEPTH(2 ** QW),
    .AW   (QW)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (lram_we),
    .waddr_i(tail),
    .wdata_i(n_len),
    .re_i   (lram_re),
    .raddr_i(head_q),
    .rdata_o(lram_rdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcount_q <= CNTW'(QUEUE_DEPTH))
    else $error("Ring count exceeds the queue depth.");

  a_latest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latest_len_q <= LW'(PAYLOAD_BYTES))
    else $error("Latest-value length exceeds the payload size.");

  a_data_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> state_q == ST_EMIT)
    else $error("Read data flagged valid outside the emit state.");

  a_fetch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (fc_q <= lim_q) && (lim_q != '0))
    else $error("Fetch index ran past the run length.");

  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_READ && rcount_q != '0) |=>
      (state_q == ST_RLEN) && (rcount_q == $past(rcount_q) - CNTW'(1)))
    else $error("Reliable read did not pop the ring.");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the priority payload FIFO with latest-value slot
// Drives command words with random gaps and checks every result word against
// a behavioral model of the reliable ring and the latest-value slot. A short
// directed sequence is followed by random payload traffic under three
// handshake idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import ppfs_pkg::*;

  localparam int QDEPTH       = DEF_QUEUE_DEPTH;
  localparam int PAYLOAD      = DEF_PAYLOAD_BYTES;
  localparam int RANDOM_WORDS = 420;
  localparam int DRAIN_LIMIT  = 200000;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_UNREL = 2'd1,
    WR_REL   = 2'd2
  } write_class_e;

  class fifo_snapshot_checker;
    logic [7:0]   ring_mem [QDEPTH][PAYLOAD];
    int           ring_len [QDEPTH];
    int           ring_head;
    int           ring_count;
    logic [7:0]   latest_mem [PAYLOAD];
    int           latest_len;
    logic [7:0]   stage_mem [PAYLOAD];
    int           stage_cnt;
    write_class_e wr_class;
    bit           too_long;
    out_word_t    expected_words [$];
    int           fail_count;
    int           checked_count;
    int           status_seen [4];

    function new();
      ring_head     = 0;
      ring_count    = 0;
      latest_len    = 0;
      fail_count    = 0;
      checked_count = 0;
      status_seen   = '{default: 0};
      drop_staging();
    endfunction

    function void drop_staging();
      stage_cnt = 0;
      wr_class  = WR_NONE;
      too_long  = 1'b0;
    endfunction

    function void push_word(kind_e k, status_e s, logic [7:0] b, logic [5:0] idx,
                            logic eor);
      out_word_t w;
      w.kind       = k;
      w.status     = s;
      w.out_byte   = b;
      w.byte_index = idx;
      w.end_of_run = eor;
      expected_words.push_back(w);
    endfunction

    function int pending_count();
      return expected_words.size();
    endfunction

    function void take_command(in_word_t w);
      write_class_e cls;
      status_e      st;
      int           slot;
      int           n;
      case (w.command)
        CMD_UNREL_WR, CMD_REL_WR: begin
          cls = (w.command == CMD_REL_WR) ? WR_REL : WR_UNREL;
          if (wr_class != cls) begin
            drop_staging();
            wr_class = cls;
          end
          if (stage_cnt < PAYLOAD) begin
            stage_mem[stage_cnt] = w.data_byte;
            stage_cnt++;
          end else begin
            too_long = 1'b1;
          end
          if (w.last_byte) begin
            if (too_long) begin
              st = STAT_TOO_LONG;
            end else if (cls == WR_REL) begin
              if (ring_count >= QDEPTH) begin
                st = STAT_FULL;
              end else begin
                slot = (ring_head + ring_count) % QDEPTH;
                for (int i = 0; i < stage_cnt; i++) ring_mem[slot][i] = stage_mem[i];
                ring_len[slot] = stage_cnt;
                ring_count++;
                st = STAT_OK;
              end
            end else if (ring_count > 0) begin
              st = STAT_PENDING;
            end else begin
              for (int i = 0; i < stage_cnt; i++) latest_mem[i] = stage_mem[i];
              latest_len = stage_cnt;
              st = STAT_OK;
            end
            status_seen[st]++;
            push_word(KIND_ACK, st, 8'd0, 6'd0, 1'b1);
            drop_staging();
          end
        end
        CMD_RESET: begin
          drop_staging();
          ring_head  = 0;
          ring_count = 0;
          latest_len = 0;
          push_word(KIND_ACK, STAT_OK, 8'd0, 6'd0, 1'b1);
        end
        default: begin
          drop_staging();
          if (ring_count > 0) begin
            n = ring_len[ring_head];
            for (int i = 0; i < n; i++)
              push_word(KIND_REL_DATA, STAT_OK, ring_mem[ring_head][i], 6'(i), i == n - 1);
            ring_head = (ring_head + 1) % QDEPTH;
            ring_count--;
          end else if (latest_len > 0) begin
            for (int i = 0; i < latest_len; i++)
              push_word(KIND_UNREL_DATA, STAT_OK, latest_mem[i], 6'(i), i == latest_len - 1);
          end else begin
            push_word(KIND_NONE, STAT_OK, 8'd0, 6'd0, 1'b1);
          end
        end
      endcase
    endfunction

    task report_error(string msg);
      fail_count++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task match_result(out_word_t got);
      out_word_t want;
      checked_count++;
      if (expected_words.size() == 0) begin
        report_error($sformatf("unexpected result word kind=%0d byte=%02h", got.kind,
                               got.out_byte));
        return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind)
        report_error($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.status !== want.status)
        report_error($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.out_byte !== want.out_byte)
        report_error($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.byte_index !== want.byte_index)
        report_error($sformatf("byte_index %0d, expected %0d", got.byte_index,
                               want.byte_index));
      if (got.end_of_run !== want.end_of_run)
        report_error($sformatf("end_of_run %0b, expected %0b", got.end_of_run,
                               want.end_of_run));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ppfs_in_if  cmd_if ();
  ppfs_out_if res_if ();

  priority_payload_fifo_with_snapshot uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  fifo_snapshot_checker board = new();

  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_word(command_e cmd, logic [7:0] b, logic last);
    in_word_t w;
    w.command   = cmd;
    w.data_byte = b;
    w.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    board.take_command(w);
    words_sent++;
  endtask

  task automatic send_payload(command_e cmd, int len, bit close);
    for (int i = 0; i < len; i++)
      send_word(cmd, 8'($urandom_range(255)), close && (i == len - 1));
  endtask

  task automatic send_read();
    send_word(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 92) return $urandom_range(5, 63);
    if (r < 96) return PAYLOAD;
    return $urandom_range(PAYLOAD + 1, PAYLOAD + 3);
  endfunction

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) board.match_result(res_if.data);
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d result words outstanding.", board.pending_count());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int directed_words;
    int op_no;
    int pick;
    int bias;
    int waited;
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    words_sent   = 0;
    set_idling(26, 82);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty read, reset acknowledge, and a latest-value slot that survives reads.
    send_read();
    send_word(CMD_RESET, 8'hFF, 1'b1);
    send_word(CMD_UNREL_WR, 8'h00, 1'b1);
    send_read();
    send_read();
    // A reset in the middle of a write discards the staged bytes.
    send_word(CMD_REL_WR, 8'hFF, 1'b0);
    send_word(CMD_RESET, 8'h00, 1'b0);
    send_read();
    send_word(CMD_UNREL_WR, 8'hFF, 1'b1);
    send_word(CMD_REL_WR, 8'hFF, 1'b0);
    send_word(CMD_REL_WR, 8'h00, 1'b1);
    send_word(CMD_UNREL_WR, 8'hA5, 1'b1);
    // A write of the other class restarts the payload.
    send_word(CMD_UNREL_WR, 8'h5A, 1'b0);
    send_word(CMD_REL_WR, 8'h3C, 1'b1);
    send_read();
    // A read in the middle of a write discards the staged bytes.
    send_word(CMD_REL_WR, 8'hC3, 1'b0);
    send_read();
    send_read();
    send_payload(CMD_REL_WR, 1, 1'b1);
    repeat (QDEPTH - 1) send_payload(CMD_REL_WR, 1, 1'b1);
    send_word(CMD_REL_WR, 8'h81, 1'b1);
    directed_words = words_sent;

    // The ring is full here: an oversized write must report too long first.
    send_payload(CMD_REL_WR, $urandom_range(PAYLOAD + 1, PAYLOAD + 3), 1'b1);
    send_payload(CMD_UNREL_WR, $urandom_range(PAYLOAD + 1, PAYLOAD + 3), 1'b1);

    op_no = 0;
    while (words_sent - directed_words < RANDOM_WORDS) begin
      if (words_sent - directed_words >= 2 * RANDOM_WORDS / 3) set_idling(0, 0);
      else if (words_sent - directed_words >= RANDOM_WORDS / 3) set_idling(82, 26);
      bias = ((op_no / 12) % 2 == 0) ? 20 : 0;
      pick = $urandom_range(99);
      if (pick < 30 + bias) begin
        send_payload(CMD_REL_WR, pick_length(), 1'b1);
      end else if (pick < 50 + bias) begin
        send_payload(CMD_UNREL_WR, pick_length(), 1'b1);
      end else if (pick < 86) begin
        send_read();
      end else if (pick < 90) begin
        send_word(CMD_RESET, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_payload($urandom_range(1) ? CMD_REL_WR : CMD_UNREL_WR, $urandom_range(1, 4),
                     1'b0);
      end
      op_no++;
    end
    cmd_if.valid <= 1'b0;

    waited = 0;
    while (board.pending_count() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (board.pending_count() > 0)
      board.report_error($sformatf("%0d result words never arrived",
                                   board.pending_count()));

    $display("Run covered %0d command words and %0d result words.", words_sent,
             board.checked_count);
    $display("Write acknowledges: %0d too long, %0d ring full, %0d reliable pending.",
             board.status_seen[STAT_TOO_LONG], board.status_seen[STAT_FULL],
             board.status_seen[STAT_PENDING]);
    if (board.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/ppfs_pkg.sv
hw/rtl/ppfs_in_if.sv
hw/rtl/ppfs_out_if.sv
hw/rtl/ppfs_ram.sv
hw/rtl/priority_payload_fifo_with_snapshot.sv
tb/tb_top.sv
